// ===== rtl/structured_mesh_element_connectivity_top_defines.svh =====
// Assertion macros for the structured mesh element connectivity block
`ifndef STRUCTURED_MESH_ELEMENT_CONNECTIVITY_TOP_DEFINES_SVH
`define STRUCTURED_MESH_ELEMENT_CONNECTIVITY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SMEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SMEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/smec_pkg.sv =====
// Shared types and constants for the mesh element connectivity block
`timescale 1ns / 1ps
package smec_pkg;

	localparam int CELL_W  = 16;
	localparam int SIDE_W  = 9;
	localparam int NODE_W  = 17;
	localparam int ELEM_W  = 18;
	localparam int COUNT_W = 18;
	localparam int NCNT_W  = 3;
	localparam int DIV_BITS = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic KIND_LINE = 1'b0;
	localparam logic KIND_QUAD = 1'b1;

	localparam logic [2:0] ET_QUAD   = 3'd1;
	localparam logic [2:0] ET_DIAG_A = 3'd2;
	localparam logic [2:0] ET_DIAG_B = 3'd3;
	localparam logic [2:0] ET_CENTER = 3'd4;

	typedef enum logic [1:0] {
		REG_MESH_KIND     = 2'd0,
		REG_ELEMENT_TYPE  = 2'd1,
		REG_NODES_PER_ROW = 2'd2,
		REG_NODE_ROWS     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CELL_W-1:0] idx;
		logic              oor;
	} job_t;

	typedef struct packed {
		logic [CELL_W-1:0] idx;
		logic              oor;
		logic [CELL_W-1:0] quo;
	} divres_t;

	typedef struct packed {
		logic               kind;
		logic [2:0]         etype;
		logic [SIDE_W-1:0]  npr;
		logic [COUNT_W-1:0] nn;
	} cfg_t;

endpackage

// ===== rtl/smec_fifo.sv =====
// Small register queue between the front and the back
`timescale 1ns / 1ps
module smec_fifo #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    fill_q;
	logic             wr_fire;
	logic             rd_fire;

	assign wr_ready = fill_q != CW'(DEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_data  = mem_q[rptr_q];
	assign wr_fire  = wr_valid && wr_ready;
	assign rd_fire  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (wr_fire) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (rd_fire) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (wr_fire && !rd_fire) begin
				fill_q <= fill_q + CW'(1);
			end else if (rd_fire && !wr_fire) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/smec_front.sv =====
// Input stage: take a cell index and flag it against the cell count
`timescale 1ns / 1ps
module smec_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cell_valid,
	output logic                           cell_ready,
	input  logic [smec_pkg::CELL_W-1:0]    cell_index,
	input  logic [smec_pkg::COUNT_W-1:0]   count,
	output logic                           push_valid,
	input  logic                           push_ready,
	output smec_pkg::job_t                 push_data
);
	import smec_pkg::*;

	logic              valid_s1;
	logic [CELL_W-1:0] cell_s1;

	assign cell_ready     = !valid_s1 || push_ready;
	assign push_valid     = valid_s1;
	assign push_data.idx  = cell_s1;
	assign push_data.oor  = COUNT_W'(cell_s1) >= count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_valid && cell_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_valid && cell_ready) begin
			cell_s1 <= cell_index;
		end
	end

endmodule

// ===== rtl/smec_div.sv =====
// Divider: index / cells per row, four quotient bits a cycle unless held
`timescale 1ns / 1ps
module smec_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  smec_pkg::job_t                job,
	input  logic                          quad,
	input  logic [smec_pkg::SIDE_W-1:0]   divisor,
	output logic                          res_valid,
	input  logic                          res_ready,
	output smec_pkg::divres_t             res
);
	import smec_pkg::*;

	localparam int NSTEP = CELL_W / DIV_BITS;
	localparam int STEP_W = $clog2(NSTEP);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SIDE_W-1:0] rem_q;
	logic [CELL_W-1:0] quo_q;
	logic [CELL_W-1:0] cell_q;
	logic              oor_q;
	divres_t           res_q;
	logic [SIDE_W:0]   r_w;
	logic [CELL_W-1:0] d_w;
	logic              finish;
	logic              finish_ok;
	logic              job_fire;

	assign finish    = busy_q && (step_q == LAST_STEP);
	assign finish_ok = !done_q || res_ready;
	assign job_ready = !busy_q || (finish && finish_ok);
	assign job_fire  = job_valid && job_ready;
	assign res_valid = done_q;
	assign res       = res_q;

	always_comb begin
		r_w = {1'b0, rem_q};
		d_w = quo_q;
		for (int j = 0; j < DIV_BITS; j++) begin
			r_w = {r_w[SIDE_W-1:0], d_w[CELL_W-1]};
			d_w = {d_w[CELL_W-2:0], 1'b0};
			if (r_w >= {1'b0, divisor}) begin
				r_w = r_w - {1'b0, divisor};
				d_w[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (finish && finish_ok) begin
				done_q <= 1'b1;
			end else if (res_ready) begin
				done_q <= 1'b0;
			end
			if (job_fire) begin
				busy_q <= 1'b1;
				step_q <= (quad && !job.oor) ? '0 : LAST_STEP;
			end else if (finish && finish_ok) begin
				busy_q <= 1'b0;
			end else if (busy_q && !finish) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_fire) begin
			cell_q <= job.idx;
			oor_q  <= job.oor;
			rem_q  <= '0;
			quo_q  <= job.idx;
		end else if (busy_q && !finish) begin
			rem_q <= r_w[SIDE_W-1:0];
			quo_q <= d_w;
		end
		if (finish && finish_ok) begin
			res_q.idx  <= cell_q;
			res_q.oor  <= oor_q;
			res_q.quo  <= d_w;
		end
	end

endmodule

// ===== rtl/smec_emit.sv =====
// Element sequencer: node numbers per cell and one element per output item
`timescale 1ns / 1ps
module smec_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  smec_pkg::divres_t             job,
	input  smec_pkg::cfg_t                cfg,
	output logic                          elem_valid,
	input  logic                          elem_ready,
	output logic [smec_pkg::ELEM_W-1:0]   element_number,
	output logic [smec_pkg::NODE_W-1:0]   node_first,
	output logic [smec_pkg::NODE_W-1:0]   node_second,
	output logic [smec_pkg::NODE_W-1:0]   node_third,
	output logic [smec_pkg::NODE_W-1:0]   node_fourth,
	output logic [smec_pkg::NCNT_W-1:0]   node_count,
	output logic                          out_of_range,
	output logic                          last_of_cell
);
	import smec_pkg::*;

	logic              busy_q;
	logic [1:0]        k_q;
	logic [1:0]        n_q;
	logic              oor_q;
	logic [NODE_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [ELEM_W-1:0] en0_q;
	logic              out_valid_q;

	logic [NODE_W-1:0] base_w, a_w, b_w, c_w, d_w, e_w, two_i, npr_w;
	logic [ELEM_W-1:0] en0_w;
	logic [1:0]        n_w;

	logic [ELEM_W-1:0] en_sel;
	logic [NODE_W-1:0] n1_sel, n2_sel, n3_sel, n4_sel;
	logic [NCNT_W-1:0] cnt_sel;

	logic load;
	logic last;
	logic take;

	assign load      = busy_q && (!out_valid_q || elem_ready);
	assign last      = k_q == n_q;
	assign job_ready = !busy_q || (load && last);
	assign take      = job_valid && job_ready;
	assign elem_valid = out_valid_q;

	always_comb begin
		base_w = NODE_W'(job.idx) + NODE_W'(job.quo);
		two_i  = {job.idx, 1'b0};
		npr_w  = NODE_W'(cfg.npr);
		e_w    = NODE_W'(cfg.nn + COUNT_W'(job.idx) + COUNT_W'(1));
		d_w    = base_w + npr_w + NODE_W'(1);
		c_w    = base_w + npr_w + NODE_W'(2);
		n_w    = 2'd0;
		en0_w  = ELEM_W'(job.idx) + ELEM_W'(1);
		if (cfg.kind == KIND_LINE) begin
			if (cfg.etype == ET_QUAD) begin
				a_w = NODE_W'(job.idx) + NODE_W'(1);
				b_w = NODE_W'(job.idx) + NODE_W'(2);
			end else begin
				a_w = two_i + NODE_W'(1);
				b_w = two_i + NODE_W'(2);
				c_w = two_i + NODE_W'(3);
			end
		end else begin
			a_w = base_w + NODE_W'(1);
			b_w = base_w + NODE_W'(2);
			case (cfg.etype)
				ET_DIAG_A, ET_DIAG_B: begin
					n_w   = 2'd1;
					en0_w = ELEM_W'(two_i) + ELEM_W'(1);
				end
				ET_CENTER: begin
					n_w   = 2'd3;
					en0_w = ELEM_W'({job.idx, 2'b00}) + ELEM_W'(1);
				end
				default: begin
					n_w = 2'd0;
				end
			endcase
		end
		if (job.oor) begin
			n_w = 2'd0;
		end
	end

	always_comb begin
		en_sel  = en0_q + ELEM_W'(k_q);
		n1_sel  = a_q;
		n2_sel  = b_q;
		n3_sel  = c_q;
		n4_sel  = '0;
		cnt_sel = NCNT_W'(3);
		if (oor_q) begin
			en_sel  = '0;
			n1_sel  = '0;
			n2_sel  = '0;
			n3_sel  = '0;
			cnt_sel = '0;
		end else if (cfg.kind == KIND_LINE) begin
			if (cfg.etype == ET_QUAD) begin
				n3_sel  = '0;
				cnt_sel = NCNT_W'(2);
			end
		end else begin
			case (cfg.etype)
				ET_QUAD: begin
					n4_sel  = d_q;
					cnt_sel = NCNT_W'(4);
				end
				ET_DIAG_A: begin
					if (k_q[0]) begin
						n2_sel = c_q;
						n3_sel = d_q;
					end
				end
				ET_DIAG_B: begin
					if (k_q[0]) begin
						n1_sel = b_q;
						n2_sel = c_q;
					end
					n3_sel = d_q;
				end
				default: begin
					n3_sel = e_q;
					case (k_q)
						2'd0: begin
							n1_sel = a_q;
							n2_sel = b_q;
						end
						2'd1: begin
							n1_sel = b_q;
							n2_sel = c_q;
						end
						2'd2: begin
							n1_sel = c_q;
							n2_sel = d_q;
						end
						default: begin
							n1_sel = d_q;
							n2_sel = a_q;
						end
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (load) begin
				k_q <= k_q + 2'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (elem_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			a_q   <= a_w;
			b_q   <= b_w;
			c_q   <= c_w;
			d_q   <= d_w;
			e_q   <= e_w;
			en0_q <= en0_w;
			n_q   <= n_w;
			oor_q <= job.oor;
		end
		if (load) begin
			element_number <= en_sel;
			node_first     <= n1_sel;
			node_second    <= n2_sel;
			node_third     <= n3_sel;
			node_fourth    <= n4_sel;
			node_count     <= cnt_sel;
			out_of_range   <= oor_q;
			last_of_cell   <= last;
		end
	end

endmodule

// ===== rtl/structured_mesh_element_connectivity_top.sv =====
// Throughput: a quad-grid cell occupies the 4-pass row divider, which takes no new cell before
// its last pass on it; line mode and out-of-range cells pass one per cycle while no quad-grid
// cell is in divider or emitter; elements leave one per cycle, each while elem_ready is high.
// Reset: arst_n clears handshake state and loads mesh_kind 1, element_type 1,
// nodes_per_row 2, node_rows 2; no clearing pass.
`timescale 1ns / 1ps
`include "structured_mesh_element_connectivity_top_defines.svh"
module structured_mesh_element_connectivity_top #(
	parameter int MAX_SIDE = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  logic [smec_pkg::CELL_W-1:0]   cell_index,
	output logic                          elem_valid,
	input  logic                          elem_ready,
	output logic [smec_pkg::ELEM_W-1:0]   element_number,
	output logic [smec_pkg::NODE_W-1:0]   node_first,
	output logic [smec_pkg::NODE_W-1:0]   node_second,
	output logic [smec_pkg::NODE_W-1:0]   node_third,
	output logic [smec_pkg::NODE_W-1:0]   node_fourth,
	output logic [smec_pkg::NCNT_W-1:0]   node_count,
	output logic                          out_of_range,
	output logic                          last_of_cell
);
	import smec_pkg::*;

	logic              mesh_kind_q;
	logic [2:0]        element_type_q;
	logic [SIDE_W-1:0] nodes_per_row_q;
	logic [SIDE_W-1:0] node_rows_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] nn_q;

	logic [SIDE_W-1:0]  npr_c, nr_c;
	logic [COUNT_W-1:0] count_d;
	logic               type_ok;
	reg_idx_t           reg_idx;
	logic               wr_fire;

	job_t    push_data;
	logic    push_valid, push_ready;
	job_t    q_data;
	logic    q_valid, q_ready;
	divres_t div_res;
	logic    div_valid, div_ready;
	cfg_t    cfg;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_fire = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_kind_q     <= KIND_QUAD;
			element_type_q  <= ET_QUAD;
			nodes_per_row_q <= SIDE_W'(2);
			node_rows_q     <= SIDE_W'(2);
		end else if (wr_fire) begin
			case (reg_idx)
				REG_MESH_KIND:     mesh_kind_q     <= pwdata[0];
				REG_ELEMENT_TYPE:  element_type_q  <= pwdata[2:0];
				REG_NODES_PER_ROW: nodes_per_row_q <= pwdata[SIDE_W-1:0];
				REG_NODE_ROWS:     node_rows_q     <= pwdata[SIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MESH_KIND:     prdata = 32'(mesh_kind_q);
			REG_ELEMENT_TYPE:  prdata = 32'(element_type_q);
			REG_NODES_PER_ROW: prdata = 32'(nodes_per_row_q);
			REG_NODE_ROWS:     prdata = 32'(node_rows_q);
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		npr_c = (int'(nodes_per_row_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : nodes_per_row_q;
		nr_c  = (int'(node_rows_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : node_rows_q;
		type_ok = element_type_q inside {[ET_QUAD:ET_CENTER]};
		if (mesh_kind_q == KIND_QUAD) begin
			if (type_ok && npr_c >= SIDE_W'(2) && nr_c >= SIDE_W'(2)) begin
				count_d = COUNT_W'({9'b0, npr_c - SIDE_W'(1)} * {9'b0, nr_c - SIDE_W'(1)});
			end else begin
				count_d = '0;
			end
		end else begin
			count_d = (npr_c >= SIDE_W'(2)) ? COUNT_W'(npr_c - SIDE_W'(1)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
			nn_q    <= COUNT_W'(4);
		end else begin
			count_q <= count_d;
			nn_q    <= COUNT_W'({9'b0, npr_c} * {9'b0, nr_c});
		end
	end

	assign cfg.kind  = mesh_kind_q;
	assign cfg.etype = element_type_q;
	assign cfg.npr   = npr_c;
	assign cfg.nn    = nn_q;

	smec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_index (cell_index),
		.count      (count_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	smec_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	smec_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_data),
		.quad      (mesh_kind_q),
		.divisor   (npr_c - SIDE_W'(1)),
		.res_valid (div_valid),
		.res_ready (div_ready),
		.res       (div_res)
	);

	smec_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (div_valid),
		.job_ready      (div_ready),
		.job            (div_res),
		.cfg            (cfg),
		.elem_valid     (elem_valid),
		.elem_ready     (elem_ready),
		.element_number (element_number),
		.node_first     (node_first),
		.node_second    (node_second),
		.node_third     (node_third),
		.node_fourth    (node_fourth),
		.node_count     (node_count),
		.out_of_range   (out_of_range),
		.last_of_cell   (last_of_cell)
	);

	`SMEC_ASSERT_IMP(a_oor_empty, elem_valid && out_of_range, last_of_cell && node_count == 3'd0 && element_number == '0, "out-of-range item carries data")
	`SMEC_ASSERT_IMP(a_count_ok, elem_valid && !out_of_range, node_count == 3'd2 || node_count == 3'd3 || node_count == 3'd4, "bad node count")
	`SMEC_ASSERT_IMP(a_unused_zero, elem_valid && node_count != 3'd4, node_fourth == '0 && (node_count != 3'd2 || node_third == '0), "unused node field not zero")
	`SMEC_ASSERT_NEXT(a_cell_burst, elem_valid && elem_ready && !last_of_cell, elem_valid, "gap inside a cell's elements")

endmodule
